/* rtl/core/gopw_pkg.sv */
// ----------------------------------------------------------------------------
// gopw_pkg
// Shared types and codes for the greedy overlap path walker.
// ----------------------------------------------------------------------------
package gopw_pkg;

    localparam logic [1:0] REQ_LOAD   = 2'd0;
    localparam logic [1:0] REQ_WALK   = 2'd1;
    localparam logic [1:0] REQ_SEARCH = 2'd2;
    localparam logic [1:0] REQ_RSVD   = 2'd3;

    localparam logic CFG_TARGET = 1'b0;
    localparam logic CFG_PROBE  = 1'b1;

    localparam int MAX_RESULTS = 64;

    // controller -> datapath
    typedef struct packed {
        logic load_req;     // capture input beat
        logic write_mem;    // write matrix entry
        logic walk_init;    // start walk at r_walk_start
        logic scan_rd;      // issue row read at scan column
        logic scan_eval;    // evaluate returned entry
        logic step;         // move to best candidate
        logic emit;         // build node result
        logic emit_oob;     // build out-of-range result
        logic emit_summary; // build search summary
        logic search_init;  // clear best summary, start at node 0
        logic search_fold;  // fold finished walk into best
        logic search_next;  // advance search start
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic [1:0] req;
        logic       load_ok;
        logic       start_ok;
        logic       scan_done;  // last column issued
        logic       found;      // candidate found
        logic       count_full; // hit result limit
        logic       search_done; // current walk starts at the last node
    } t_sts;

endpackage

/* rtl/core/gopw_if.sv */
// ----------------------------------------------------------------------------
// gopw_req_if / gopw_rsp_if
// Valid/ready channels for request and result beats.
// ----------------------------------------------------------------------------
interface gopw_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] req_type;
    logic [5:0] row_node;
    logic [5:0] col_node;
    logic [5:0] shift_value;
    logic [5:0] start_node;
    modport source (output valid, req_type, row_node, col_node, shift_value, start_node,
                    input ready);
    modport sink   (input valid, req_type, row_node, col_node, shift_value, start_node,
                    output ready);
endinterface

interface gopw_rsp_if;
    logic        valid;
    logic        ready;
    logic [5:0]  node;
    logic [5:0]  added_chars;
    logic [11:0] total_length;
    logic [6:0]  visited_count;
    logic        from_search;
    logic        last;
    modport source (output valid, node, added_chars, total_length, visited_count,
                    from_search, last, input ready);
    modport sink   (input valid, node, added_chars, total_length, visited_count,
                    from_search, last, output ready);
endinterface

/* rtl/core/greedy_overlap_path_walker.sv */
// ----------------------------------------------------------------------------
// greedy_overlap_path_walker
// Greedy nearest-neighbor walk over an overlap shift matrix held in RAM.
// ----------------------------------------------------------------------------
// Channel | Dir | Beat
// i_req   | in  | req_type, row_node, col_node, shift_value, start_node
// o_rsp   | out | node, added_chars, total_length, visited_count, from_search, last
// cfg     | in  | i_cfg_we, i_cfg_idx, i_cfg_data
//
// Each walk step scans one matrix row through the RAM read port, one entry
// a cycle. A search runs NODE_COUNT walks back to back, up to NODE_COUNT^2
// row scans. One request is in flight at a time; a stalled result beat holds
// the walk. Synchronous active-low reset; the matrix has no reset.
// ----------------------------------------------------------------------------
module greedy_overlap_path_walker #(
    parameter int NODE_COUNT  = 64,
    parameter int SHIFT_BITS  = 6,
    parameter int LENGTH_BITS = 12
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    gopw_req_if.sink    i_req,
    gopw_rsp_if.source  o_rsp,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [11:0] i_cfg_data
);
    gopw_pkg::t_cmd w_cmd;
    gopw_pkg::t_sts w_sts;

    gopw_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_rsp.valid),
        .o_out_last  (o_rsp.last),
        .i_out_ready (o_rsp.ready),
        .o_cmd       (w_cmd),
        .i_sts       (w_sts)
    );

    gopw_datapath #(
        .NODE_COUNT(NODE_COUNT), .SHIFT_BITS(SHIFT_BITS), .LENGTH_BITS(LENGTH_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .i_req_type    (i_req.req_type),
        .i_row_node    (i_req.row_node),
        .i_col_node    (i_req.col_node),
        .i_shift_value (i_req.shift_value),
        .i_start_node  (i_req.start_node),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .o_node        (o_rsp.node),
        .o_added       (o_rsp.added_chars),
        .o_total       (o_rsp.total_length),
        .o_count       (o_rsp.visited_count),
        .o_from_search (o_rsp.from_search)
    );
endmodule

/* rtl/core/gopw_ram.sv */
// ----------------------------------------------------------------------------
// gopw_ram
// Single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module gopw_ram #(
    parameter int WIDTH = 6,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

/* rtl/core/gopw_datapath.sv */
// ----------------------------------------------------------------------------
// gopw_datapath
// Request capture, matrix store, row scan, walk and search bookkeeping.
// ----------------------------------------------------------------------------
module gopw_datapath #(
    parameter int NODE_COUNT  = 64,
    parameter int SHIFT_BITS  = 6,
    parameter int LENGTH_BITS = 12
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  gopw_pkg::t_cmd    i_cmd,
    output gopw_pkg::t_sts    o_sts,
    input  logic [1:0]        i_req_type,
    input  logic [5:0]        i_row_node,
    input  logic [5:0]        i_col_node,
    input  logic [5:0]        i_shift_value,
    input  logic [5:0]        i_start_node,
    input  logic              i_cfg_we,
    input  logic              i_cfg_idx,
    input  logic [11:0]       i_cfg_data,
    output logic [5:0]        o_node,
    output logic [5:0]        o_added,
    output logic [11:0]       o_total,
    output logic [6:0]        o_count,
    output logic              o_from_search
);
    localparam int NB = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
    localparam int CB = $clog2(gopw_pkg::MAX_RESULTS + 1);
    localparam int LB = ((LENGTH_BITS > 12) ? LENGTH_BITS : 12) + 1;

    logic [1:0]             r_req;
    logic [5:0]             r_row, r_col, r_shv, r_start;
    logic [11:0]            r_target;
    logic [5:0]             r_probe;
    logic [NODE_COUNT-1:0]  r_visited;
    logic [NB-1:0]          r_cur, r_walk_start;
    logic [LENGTH_BITS-1:0] r_len;
    logic [5:0]             r_added;
    logic [CB-1:0]          r_cnt;
    logic [NB-1:0]          r_col_rd, r_col_ev;
    logic                   r_found;
    logic [NB-1:0]          r_best;
    logic [SHIFT_BITS-1:0]  r_best_s;
    logic [NB-1:0]          r_b_node;
    logic [LENGTH_BITS-1:0] r_b_len;
    logic [CB-1:0]          r_b_cnt;
    logic                   r_b_any;
    logic [SHIFT_BITS-1:0]  w_rdata;
    logic [LB-1:0]          w_sum;
    logic                   w_cand;

    gopw_ram #(.WIDTH(SHIFT_BITS), .DEPTH(1 << (2 * NB))) u_mat (
        .i_clk   (i_clk),
        .i_we    (i_cmd.write_mem),
        .i_waddr ({NB'(r_row), NB'(r_col)}),
        .i_wdata (SHIFT_BITS'(r_shv)),
        .i_raddr ({r_cur, r_col_rd}),
        .o_rdata (w_rdata)
    );

    assign w_sum  = LB'(r_len) + LB'(w_rdata);
    assign w_cand = (w_rdata != '0) && !r_visited[r_col_ev] && (w_sum <= LB'(r_target))
                    && (!r_found || w_rdata < r_best_s);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target  <= 12'd1024;
            r_probe   <= 6'd10;
            r_req     <= '0;
            r_visited <= '0;
            r_cur     <= '0;
            r_len     <= '0;
            r_cnt     <= '0;
            r_found   <= 1'b0;
            r_b_any   <= 1'b0;
            r_col_rd  <= '0;
            r_b_node  <= '0;
            r_b_len   <= '0;
            r_b_cnt   <= '0;
            r_walk_start <= '0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == gopw_pkg::CFG_TARGET) r_target <= i_cfg_data;
                else r_probe <= i_cfg_data[5:0];
            end
            if (i_cmd.load_req) begin
                r_req   <= i_req_type;
                r_row   <= i_row_node;
                r_col   <= i_col_node;
                r_shv   <= i_shift_value;
                r_start <= i_start_node;
                r_walk_start <= NB'(i_start_node);
            end
            if (i_cmd.search_init) begin
                r_walk_start  <= '0;
                r_b_any       <= 1'b0;
            end
            if (i_cmd.search_next) begin
                if (32'(r_walk_start) != NODE_COUNT - 1) r_walk_start <= r_walk_start + 1'b1;
            end
            if (i_cmd.search_fold) begin
                if (!r_b_any || r_cnt > r_b_cnt || (r_cnt == r_b_cnt && r_len > r_b_len)) begin
                    r_b_any  <= 1'b1;
                    r_b_cnt  <= r_cnt;
                    r_b_len  <= r_len;
                    r_b_node <= r_walk_start;
                end
            end
            if (i_cmd.walk_init) begin
                r_visited <= NODE_COUNT'(1) << r_walk_start;
                r_cur   <= r_walk_start;
                r_len   <= LENGTH_BITS'(r_probe);
                r_added <= r_probe;
                r_cnt   <= CB'(1);
            end
            if (i_cmd.scan_rd) begin
                if (i_cmd.step || i_cmd.walk_init) r_col_rd <= '0;
                else r_col_rd <= r_col_rd + 1'b1;
            end else begin
                r_col_rd <= '0;
            end
            r_col_ev <= r_col_rd;
            if (i_cmd.walk_init || i_cmd.step) begin
                r_found <= 1'b0;
            end else if (i_cmd.scan_eval && w_cand) begin
                r_found  <= 1'b1;
                r_best   <= r_col_ev;
                r_best_s <= w_rdata;
            end
            if (i_cmd.step) begin
                r_visited[r_best] <= 1'b1;
                r_cur   <= r_best;
                r_len   <= r_len + LENGTH_BITS'(r_best_s);
                r_added <= 6'(r_best_s);
                r_cnt   <= r_cnt + 1'b1;
            end
        end
    end

    // result builder
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            o_node        <= 6'(r_cur);
            o_added       <= r_added;
            o_total       <= 12'(r_len);
            o_count       <= 7'(r_cnt);
            o_from_search <= 1'b0;
        end else if (i_cmd.emit_oob) begin
            o_node        <= r_start;
            o_added       <= '0;
            o_total       <= '0;
            o_count       <= '0;
            o_from_search <= 1'b0;
        end else if (i_cmd.emit_summary) begin
            o_node        <= 6'(r_b_node);
            o_added       <= '0;
            o_total       <= 12'(r_b_len);
            o_count       <= 7'(r_b_cnt);
            o_from_search <= 1'b1;
        end
    end

    always_comb begin
        o_sts.req         = r_req;
        o_sts.load_ok     = (32'(r_row) < NODE_COUNT) && (32'(r_col) < NODE_COUNT);
        o_sts.start_ok    = 32'(r_start) < NODE_COUNT;
        o_sts.scan_done   = 32'(r_col_rd) == NODE_COUNT - 1;
        o_sts.found       = r_found || (i_cmd.scan_eval && w_cand);
        o_sts.count_full  = 32'(r_cnt) >= gopw_pkg::MAX_RESULTS;
        o_sts.search_done = 32'(r_walk_start) == NODE_COUNT - 1;
    end
endmodule

/* rtl/core/gopw_ctrl.sv */
// ----------------------------------------------------------------------------
// gopw_ctrl
// Sequencer for load, walk and search requests and result handshake.
// ----------------------------------------------------------------------------
module gopw_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    output logic           o_out_valid,
    output logic           o_out_last,
    input  logic           i_out_ready,
    output gopw_pkg::t_cmd o_cmd,
    input  gopw_pkg::t_sts i_sts
);
    typedef enum logic [3:0] {
        S_IDLE, S_DECODE, S_WINIT, S_EMIT, S_SCAN, S_DRAIN, S_DECIDE, S_STEP, S_OUT,
        S_FOLD, S_SUM
    } t_state;

    t_state r_state;
    logic   r_valid, r_last, r_search;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_valid;
    assign o_out_last  = r_last;

    always_comb begin
        o_cmd = '0;
        o_cmd.load_req = (r_state == S_IDLE) && i_in_valid;
        unique case (r_state)
            S_DECODE: begin
                o_cmd.write_mem   = (i_sts.req == gopw_pkg::REQ_LOAD) && i_sts.load_ok;
                o_cmd.search_init = (i_sts.req == gopw_pkg::REQ_SEARCH);
                o_cmd.emit_oob    = (i_sts.req == gopw_pkg::REQ_WALK) && !i_sts.start_ok;
            end
            S_WINIT:  o_cmd.walk_init = 1'b1;
            S_EMIT:   o_cmd.emit      = !r_search;
            S_SCAN: begin
                o_cmd.scan_rd   = !i_sts.scan_done;
                o_cmd.scan_eval = 1'b1;
            end
            S_DRAIN:  o_cmd.scan_eval = 1'b1;
            S_STEP:   o_cmd.step      = 1'b1;
            S_FOLD: begin
                o_cmd.search_fold = 1'b1;
                o_cmd.search_next = 1'b1;
            end
            S_SUM:    o_cmd.emit_summary = 1'b1;
            default: ;
        endcase
    end

    // Second S_SCAN cycle sees column 0 a second time; a repeat cannot change the pick
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_valid  <= 1'b0;
            r_last   <= 1'b0;
            r_search <= 1'b0;
        end else begin
            if (r_valid && i_out_ready) r_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: if (i_in_valid) r_state <= S_DECODE;
                S_DECODE: begin
                    unique case (i_sts.req)
                        gopw_pkg::REQ_WALK: begin
                            r_search <= 1'b0;
                            if (i_sts.start_ok) begin
                                r_state <= S_WINIT;
                            end else begin
                                r_valid <= 1'b1;
                                r_last  <= 1'b1;
                                r_state <= S_OUT;
                            end
                        end
                        gopw_pkg::REQ_SEARCH: begin
                            r_search <= 1'b1;
                            r_state  <= S_WINIT;
                        end
                        default: r_state <= S_IDLE;
                    endcase
                end
                S_WINIT: r_state <= S_EMIT;
                S_EMIT: begin
                    if (i_sts.count_full) begin
                        if (r_search) begin
                            r_state <= S_FOLD;
                        end else begin
                            r_valid <= 1'b1;
                            r_last  <= 1'b1;
                            r_state <= S_OUT;
                        end
                    end else begin
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: if (i_sts.scan_done) r_state <= S_DRAIN;
                S_DRAIN: r_state <= S_DECIDE;
                S_DECIDE: begin
                    if (i_sts.found) begin
                        if (!r_search) r_valid <= 1'b1;
                        r_last  <= 1'b0;
                        r_state <= r_search ? S_STEP : S_OUT;
                    end else if (r_search) begin
                        r_state <= S_FOLD;
                    end else begin
                        r_valid <= 1'b1;
                        r_last  <= 1'b1;
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (i_out_ready) begin
                        r_state <= r_last ? S_IDLE : S_STEP;
                    end
                end
                S_STEP: r_state <= S_EMIT;
                S_FOLD: r_state <= i_sts.search_done ? S_SUM : S_WINIT;
                S_SUM: begin
                    r_valid <= 1'b1;
                    r_last  <= 1'b1;
                    r_state <= S_OUT;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
